[src/ry422_pkg.sv]
// constants and arithmetic helpers for the rgb30 to yuyv 4:2:2 converter
// no dependencies

package ry422_pkg;

	localparam int PIX_W  = 32;
	localparam int COMP_W = 10;
	localparam int OUT_W  = 8;
	localparam int ACC_W  = 18;

	localparam int R_LSB = 2;
	localparam int G_LSB = 12;
	localparam int B_LSB = 22;

	localparam logic [ACC_W-1:0] Y_R   = ACC_W'(57);
	localparam logic [ACC_W-1:0] Y_G   = ACC_W'(148);
	localparam logic [ACC_W-1:0] Y_B   = ACC_W'(13);
	localparam logic [ACC_W-1:0] Y_OFS = ACC_W'(16384);

	localparam logic [ACC_W-1:0] U_B   = ACC_W'(112);
	localparam logic [ACC_W-1:0] U_G   = ACC_W'(102);
	localparam logic [ACC_W-1:0] U_R   = ACC_W'(9);
	localparam logic [ACC_W-1:0] V_R   = ACC_W'(112);
	localparam logic [ACC_W-1:0] V_G   = ACC_W'(80);
	localparam logic [ACC_W-1:0] V_B   = ACC_W'(31);
	localparam logic [ACC_W-1:0] C_OFS = ACC_W'(131072);

	typedef logic [COMP_W-1:0] comp_t;
	typedef logic [OUT_W-1:0]  samp_t;

	typedef struct packed {
		comp_t r;
		comp_t g;
		comp_t b;
	} rgb_t;

	function automatic rgb_t unpack_f(input logic [PIX_W-1:0] w);
		rgb_t p;
		p.r = w[R_LSB +: COMP_W];
		p.g = w[G_LSB +: COMP_W];
		p.b = w[B_LSB +: COMP_W];
		return p;
	endfunction

	function automatic samp_t luma_f(input rgb_t p);
		logic [ACC_W-1:0] acc;
		acc = Y_R * ACC_W'(p.r) + Y_G * ACC_W'(p.g) + Y_B * ACC_W'(p.b) + Y_OFS;
		return acc[ACC_W-1 -: OUT_W];
	endfunction

	// sums never go negative for 10-bit components
	function automatic samp_t chroma_u_f(input rgb_t p);
		logic [ACC_W-1:0] acc;
		acc = U_B * ACC_W'(p.b) + C_OFS - U_G * ACC_W'(p.g) - U_R * ACC_W'(p.r);
		return acc[ACC_W-1 -: OUT_W];
	endfunction

	function automatic samp_t chroma_v_f(input rgb_t p);
		logic [ACC_W-1:0] acc;
		acc = V_R * ACC_W'(p.r) + C_OFS - V_G * ACC_W'(p.g) - V_B * ACC_W'(p.b);
		return acc[ACC_W-1 -: OUT_W];
	endfunction

	function automatic rgb_t avg_f(input rgb_t a, input rgb_t b);
		logic [COMP_W:0] sr;
		logic [COMP_W:0] sg;
		logic [COMP_W:0] sb;
		rgb_t o;
		sr = {1'b0, a.r} + {1'b0, b.r};
		sg = {1'b0, a.g} + {1'b0, b.g};
		sb = {1'b0, a.b} + {1'b0, b.b};
		o.r = sr[COMP_W:1];
		o.g = sg[COMP_W:1];
		o.b = sb[COMP_W:1];
		return o;
	endfunction

endpackage

[src/rgb30_to_yuyv422_unit.sv]
// rgb30 to yuyv 4:2:2 converter, input register plus result register
// depends on ry422_pkg

// Takes one packed 30-bit RGB pixel per transfer (red bits 2-11, green 12-21,
// blue 22-31) and emits one Y0,U,Y1,V result for every pixel pair of a row.
// row_start restarts the pairing and drops a held unpaired pixel. A pixel is
// accepted every cycle while the output side keeps up; a pixel waits in the
// input register, and when the second pixel of a pair leaves it the pair
// result is loaded into the result register.
// in_ready follows out_ready combinationally only when both registers are full.

module rgb30_to_yuyv422_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ry422_pkg::PIX_W-1:0] pixel_word,
	input  logic                        row_start,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ry422_pkg::OUT_W-1:0] luma_even,
	output logic [ry422_pkg::OUT_W-1:0] chroma_u,
	output logic [ry422_pkg::OUT_W-1:0] luma_odd,
	output logic [ry422_pkg::OUT_W-1:0] chroma_v
);
	import ry422_pkg::*;

	logic              valid_s1;
	logic [PIX_W-1:0]  pixel_s1;
	logic              row_start_s1;

	logic              odd_phase_q;
	rgb_t              held_pix_q;
	samp_t             held_luma_q;

	logic              out_valid_q;
	samp_t             luma_even_q;
	samp_t             chroma_u_q;
	samp_t             luma_odd_q;
	samp_t             chroma_v_q;

	rgb_t              pix;
	rgb_t              avg;
	samp_t             luma;
	logic              pair_done;
	logic              out_free;
	logic              advance;

	always_comb begin
		pix       = unpack_f(pixel_s1);
		luma      = luma_f(pix);
		avg       = avg_f(held_pix_q, pix);
		pair_done = odd_phase_q & ~row_start_s1;
		out_free  = ~out_valid_q | out_ready;
		advance   = valid_s1 & (~pair_done | out_free);
	end

	assign in_ready = ~valid_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pixel_s1     <= pixel_word;
			row_start_s1 <= row_start;
		end
	end

	// pairing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_phase_q <= 1'b0;
			held_pix_q  <= '0;
			held_luma_q <= '0;
		end else if (advance) begin
			if (pair_done) begin
				odd_phase_q <= 1'b0;
			end else begin
				odd_phase_q <= 1'b1;
				held_pix_q  <= pix;
				held_luma_q <= luma;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && pair_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pair_done) begin
			luma_even_q <= held_luma_q;
			chroma_u_q  <= chroma_u_f(avg);
			luma_odd_q  <= luma;
			chroma_v_q  <= chroma_v_f(avg);
		end
	end

	assign out_valid = out_valid_q;
	assign luma_even = luma_even_q;
	assign chroma_u  = chroma_u_q;
	assign luma_odd  = luma_odd_q;
	assign chroma_v  = chroma_v_q;

endmodule
